[rtl/assert_macros.svh]
// Assertion macros shared by the load/store unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define LSU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/lsu_pkg.sv]
// ----------------------------------------------------------------------------
// lsu_pkg
// Types and constants of the load/store unit.
// ----------------------------------------------------------------------------
package lsu_pkg;
  localparam int REG_COUNT = 16;
  localparam int REG_W = $clog2(REG_COUNT);
  localparam int DR_INDEX = 0;
  localparam int SP_INDEX = 15;
  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int QDEPTH = 2;

  localparam logic [3:0] OP_PUSH = 4'd14;
  localparam logic [3:0] OP_POP = 4'd15;
  localparam logic [2:0] K_REG = 3'd0;
  localparam logic [2:0] K_REG_DR = 3'd1;
  localparam logic [2:0] K_PC_DR = 3'd2;
  localparam logic [2:0] K_PC_DR16 = 3'd3;
  localparam logic [2:0] K_REG_IMM = 3'd4;
  localparam logic [2:0] K_DR = 3'd5;
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  typedef struct packed {
    logic [3:0]  operation;
    logic [1:0]  access_size;
    logic        zero_extend;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic signed [15:0] displacement;
    logic [31:0] instr_addr;
  } lsu_in_t;

  typedef struct packed {
    logic [31:0] eff_addr;
    logic [31:0] moved_value;
    logic [3:0]  dest_index;
    logic        reg_written;
  } lsu_out_t;

  // Classified instruction as passed from the front end to the back end.
  typedef struct packed {
    logic        push;
    logic        pop;
    logic        load;
    logic [2:0]  kind;
    logic [2:0]  bytes;
    logic        zext;
    logic [REG_W-1:0] rn;
    logic [REG_W-1:0] rm;
    logic [31:0] imm;
    logic [31:0] pc2;
  } lsu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADDR, ST_MEM, ST_WAIT, ST_DONE
  } lsu_state_t;
endpackage

[rtl/lsu_front.sv]
// ----------------------------------------------------------------------------
// lsu_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lsu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lsu_pkg::lsu_in_t  cmd,
  output logic              full,
  output logic              q_valid,
  output lsu_pkg::lsu_op_t  q_op,
  input  logic              q_pop
);
  lsu_pkg::lsu_op_t op_c;
  lsu_pkg::lsu_op_t q [lsu_pkg::QDEPTH];
  logic [$clog2(lsu_pkg::QDEPTH):0] count;
  logic wptr, rptr;
  logic push_q;

  always_comb begin
    op_c.push = cmd.operation == lsu_pkg::OP_PUSH;
    op_c.pop = cmd.operation == lsu_pkg::OP_POP;
    op_c.load = cmd.operation[0];
    op_c.kind = cmd.operation[3:1];
    case (cmd.access_size)
      lsu_pkg::SZ_BYTE: op_c.bytes = 3'd1;
      lsu_pkg::SZ_WORD: op_c.bytes = 3'd2;
      default: op_c.bytes = 3'd4;
    endcase
    if (op_c.push || op_c.pop) op_c.bytes = 3'd4;
    op_c.zext = cmd.zero_extend;
    op_c.rn = cmd.first_reg[lsu_pkg::REG_W-1:0];
    op_c.rm = cmd.second_reg[lsu_pkg::REG_W-1:0];
    op_c.imm = {{16{cmd.displacement[15]}}, cmd.displacement};
    op_c.pc2 = cmd.instr_addr + 32'd2;
  end

  assign full = count == ($clog2(lsu_pkg::QDEPTH)+1)'(lsu_pkg::QDEPTH);
  assign push_q = start && !full;
  assign q_valid = count != '0;
  assign q_op = q[rptr];

  always_ff @(posedge clk) begin
    if (push_q) q[wptr] <= op_c;
    if (rst) begin
      count <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push_q) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + (push_q ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end
endmodule

[rtl/lsu_back.sv]
// ----------------------------------------------------------------------------
// lsu_back
// Register file, data memory and the sequencer that carries out one access.
// ----------------------------------------------------------------------------
module lsu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lsu_pkg::lsu_op_t  q_op,
  output logic              q_pop,
  output logic              idle,
  output logic              done,
  output lsu_pkg::lsu_out_t res
);
  lsu_pkg::lsu_state_t state, state_next;
  lsu_pkg::lsu_op_t op;
  logic [31:0] regs [lsu_pkg::REG_COUNT];
  logic [7:0] mem [lsu_pkg::MEM_BYTES];
  logic [31:0] addr, val, dr, sp, base, a_c, v_c, ld;
  logic [1:0] idx;
  logic [7:0] rdata;
  logic [31:0] byte_addr;
  localparam logic [lsu_pkg::REG_W-1:0] DR_I = lsu_pkg::REG_W'(lsu_pkg::DR_INDEX);
  localparam logic [lsu_pkg::REG_W-1:0] SP_I = lsu_pkg::REG_W'(lsu_pkg::SP_INDEX);

  assign dr = regs[DR_I];
  assign sp = regs[SP_I];
  assign base = op.load ? regs[op.rm] : regs[op.rn];
  assign byte_addr = addr + {30'd0, idx};

  always_comb begin
    if (op.push) a_c = sp - 32'd4;
    else if (op.pop) a_c = sp;
    else begin
      case (op.kind)
        lsu_pkg::K_REG: a_c = base;
        lsu_pkg::K_REG_DR: a_c = base + dr * {29'd0, op.bytes};
        lsu_pkg::K_PC_DR: a_c = op.pc2 + dr;
        lsu_pkg::K_PC_DR16: a_c = op.pc2 + {dr[27:0], 4'd0} + op.imm;
        lsu_pkg::K_REG_IMM: a_c = base + op.imm * {29'd0, op.bytes};
        lsu_pkg::K_DR: a_c = dr;
        default: a_c = op.pc2 + op.imm;
      endcase
    end
    if (op.push) v_c = (op.rn == SP_I) ? sp - 32'd4 : regs[op.rn];
    else if (op.kind == lsu_pkg::K_REG || op.kind == lsu_pkg::K_REG_DR ||
             op.kind == lsu_pkg::K_REG_IMM) v_c = regs[op.rm];
    else v_c = regs[op.rn];
    if (op.bytes == 3'd1) v_c = {24'd0, v_c[7:0]};
    else if (op.bytes == 3'd2) v_c = {16'd0, v_c[15:0]};
  end

  always_comb begin
    ld = val;
    if (!op.zext && op.bytes == 3'd1) ld = {{24{val[7]}}, val[7:0]};
    if (!op.zext && op.bytes == 3'd2) ld = {{16{val[15]}}, val[15:0]};
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      lsu_pkg::ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = lsu_pkg::ST_ADDR;
      end
      lsu_pkg::ST_ADDR: state_next = lsu_pkg::ST_MEM;
      lsu_pkg::ST_MEM: if ({1'b0, idx} == op.bytes - 3'd1)
        state_next = (op.load || op.pop) ? lsu_pkg::ST_WAIT : lsu_pkg::ST_DONE;
      lsu_pkg::ST_WAIT: state_next = lsu_pkg::ST_DONE;
      lsu_pkg::ST_DONE: state_next = lsu_pkg::ST_IDLE;
      default: state_next = lsu_pkg::ST_IDLE;
    endcase
  end

  assign idle = state == lsu_pkg::ST_IDLE;
  assign done = state == lsu_pkg::ST_DONE;
  assign res.eff_addr = addr;
  assign res.moved_value = op.load ? ld : val;
  assign res.dest_index = (op.load || op.pop) ? 4'(op.rn) : 4'd0;
  assign res.reg_written = (op.load || op.pop) && !op.push;

  always_ff @(posedge clk) begin
    rdata <= mem[byte_addr[lsu_pkg::MEM_AW-1:0]];
    if (state == lsu_pkg::ST_MEM && !(op.load || op.pop))
      mem[byte_addr[lsu_pkg::MEM_AW-1:0]] <= val[8*idx +: 8];
  end

  always_ff @(posedge clk) begin
    if (q_pop) op <= q_op;
    if (rst) begin
      state <= lsu_pkg::ST_IDLE;
      for (int i = 0; i < lsu_pkg::REG_COUNT; i++) regs[i] <= 32'd0;
    end else begin
      state <= state_next;
      case (state)
        lsu_pkg::ST_ADDR: begin
          addr <= a_c;
          val <= (op.load || op.pop) ? 32'd0 : v_c;
          idx <= 2'd0;
          if (op.push) regs[SP_I] <= sp - 32'd4;
        end
        lsu_pkg::ST_MEM: begin
          idx <= idx + 2'd1;
          if ((op.load || op.pop) && idx != 2'd0) val[8*(idx-2'd1) +: 8] <= rdata;
        end
        lsu_pkg::ST_WAIT: begin
          val[8*(op.bytes[1:0] == 2'd0 ? 2'd3 : op.bytes[1:0] - 2'd1) +: 8] <= rdata;
        end
        lsu_pkg::ST_DONE: begin
          if (op.pop) begin
            if (op.rn != SP_I) regs[op.rn] <= val;
            regs[SP_I] <= (op.rn == SP_I) ? val + 32'd4 : sp + 32'd4;
          end else if (op.load) regs[op.rn] <= ld;
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/load_store_unit_top.sv]
// ----------------------------------------------------------------------------
// load_store_unit_top
// Memory-move unit with a command queue, register file and byte memory.
// ----------------------------------------------------------------------------
// Channel | Handshake           | Payload
// command | start, busy         | cmd (lsu_in_t)
// result  | done strobe         | result (lsu_out_t)
// An item is sequenced one accessed byte at a time on the single memory port,
// plus address, read-wait and write-back steps in the back-end sequencer.
// Two commands can wait in the queue while the back end works.
// Reset is synchronous and clears the register file and the queue.
// The receiver cannot stall; each result is shown for one cycle.
`include "assert_macros.svh"
module load_store_unit_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lsu_pkg::lsu_in_t  cmd,
  output logic              busy,
  output logic              done,
  output lsu_pkg::lsu_out_t result
);
  logic q_valid, q_pop, idle, full;
  lsu_pkg::lsu_op_t q_op;

  lsu_front u_front (.clk, .rst, .start, .cmd, .full, .q_valid, .q_op, .q_pop);
  lsu_back u_back (.clk, .rst, .q_valid, .q_op, .q_pop, .idle, .done, .res(result));

  assign busy = full;

  `LSU_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, idle && q_valid, "pop while back end busy")
  `LSU_ASSERT_NEXT(a_done_one, clk, rst, done, !done, "result strobe longer than a cycle")
  `LSU_ASSERT_IMP(a_done_nopop, clk, rst, done, !q_pop, "pop during result")
endmodule

[bench/load_store_unit_top_test.sv]
// ----------------------------------------------------------------------------
// load_store_unit_top_test
// Self-checking bench for the load/store unit. Commands are predicted as
// they are generated, against a private copy of the register file and the
// byte memory. A clocked driver sends them with random gaps, and a clocked
// monitor compares every result strobe with the oldest expected result.
// Loads are steered away from memory bytes that no store has written.
// ----------------------------------------------------------------------------
module load_store_unit_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    lsu_pkg::lsu_in_t cmd;
    bit      drain;
  } pending_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  lsu_pkg::lsu_in_t  cmd = '0;
  logic     busy;
  logic     done;
  lsu_pkg::lsu_out_t result;

  load_store_unit_top dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] model_regs [lsu_pkg::REG_COUNT];
  logic [7:0]  model_mem [lsu_pkg::MEM_BYTES];
  bit          mem_valid [lsu_pkg::MEM_BYTES];

  pending_t    cmd_queue[$];
  lsu_pkg::lsu_out_t expected_results[$];
  int          sent_count = 0;
  int          recv_count = 0;
  int          errors = 0;
  int          cycles = 0;

  function automatic int access_bytes(lsu_pkg::lsu_in_t c);
    if (c.operation == lsu_pkg::OP_PUSH || c.operation == lsu_pkg::OP_POP) return 4;
    if (c.access_size == lsu_pkg::SZ_BYTE) return 1;
    if (c.access_size == lsu_pkg::SZ_WORD) return 2;
    return 4;
  endfunction

  function automatic logic [31:0] access_address(lsu_pkg::lsu_in_t c);
    logic [31:0] imm;
    logic [31:0] pc2;
    logic [31:0] dr;
    logic [31:0] base;
    imm = {{16{c.displacement[15]}}, c.displacement};
    pc2 = c.instr_addr + 32'd2;
    dr = model_regs[lsu_pkg::DR_INDEX];
    if (c.operation == lsu_pkg::OP_PUSH) return model_regs[lsu_pkg::SP_INDEX] - 32'd4;
    if (c.operation == lsu_pkg::OP_POP) return model_regs[lsu_pkg::SP_INDEX];
    base = c.operation[0] ? model_regs[c.second_reg] : model_regs[c.first_reg];
    case (c.operation[3:1])
      lsu_pkg::K_REG:     return base;
      lsu_pkg::K_REG_DR:  return base + dr * access_bytes(c);
      lsu_pkg::K_PC_DR:   return pc2 + dr;
      lsu_pkg::K_PC_DR16: return pc2 + dr * 32'd16 + imm;
      lsu_pkg::K_REG_IMM: return base + imm * access_bytes(c);
      lsu_pkg::K_DR:      return dr;
      default:            return pc2 + imm;
    endcase
  endfunction

  function automatic bit reads_unwritten(lsu_pkg::lsu_in_t c);
    logic [31:0] a;
    a = access_address(c);
    if (c.operation == lsu_pkg::OP_PUSH || !c.operation[0]) return 1'b0;
    for (int i = 0; i < access_bytes(c); i++)
      if (!mem_valid[(a + i) % lsu_pkg::MEM_BYTES]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic lsu_pkg::lsu_out_t execute_move(lsu_pkg::lsu_in_t c);
    lsu_pkg::lsu_out_t r;
    logic [31:0] a;
    logic [31:0] v;
    int          n;
    a = access_address(c);
    n = access_bytes(c);
    v = '0;
    r = '0;
    r.eff_addr = a;
    if (c.operation == lsu_pkg::OP_PUSH || !c.operation[0]) begin
      if (c.operation == lsu_pkg::OP_PUSH) begin
        model_regs[lsu_pkg::SP_INDEX] = a;
        v = model_regs[c.first_reg];
      end else if (c.operation[3:1] == lsu_pkg::K_REG ||
                   c.operation[3:1] == lsu_pkg::K_REG_DR ||
                   c.operation[3:1] == lsu_pkg::K_REG_IMM) begin
        v = model_regs[c.second_reg];
      end else begin
        v = model_regs[c.first_reg];
      end
      if (n == 1) v = v & 32'hFF;
      else if (n == 2) v = v & 32'hFFFF;
      for (int i = 0; i < n; i++) begin
        model_mem[(a + i) % lsu_pkg::MEM_BYTES] = v[8*i +: 8];
        mem_valid[(a + i) % lsu_pkg::MEM_BYTES] = 1'b1;
      end
    end else begin
      for (int i = 0; i < n; i++) v[8*i +: 8] = model_mem[(a + i) % lsu_pkg::MEM_BYTES];
      if (c.operation != lsu_pkg::OP_POP && !c.zero_extend) begin
        if (n == 1 && v[7]) v = v | 32'hFFFFFF00;
        else if (n == 2 && v[15]) v = v | 32'hFFFF0000;
      end
      model_regs[c.first_reg] = v;
      if (c.operation == lsu_pkg::OP_POP)
        model_regs[lsu_pkg::SP_INDEX] = model_regs[lsu_pkg::SP_INDEX] + 32'd4;
      r.dest_index = c.first_reg;
      r.reg_written = 1'b1;
    end
    r.moved_value = v;
    return r;
  endfunction

  task automatic queue_command(lsu_pkg::lsu_in_t c, bit drain);
    pending_t p;
    if (reads_unwritten(c)) c.operation = c.operation - 4'd1;
    p.cmd = c;
    p.drain = drain;
    expected_results.push_back(execute_move(c));
    cmd_queue.push_back(p);
  endtask

  function automatic lsu_pkg::lsu_in_t random_command(bit push_sp);
    lsu_pkg::lsu_in_t c;
    c.operation = 4'($urandom_range(0, 15));
    c.access_size = 2'($urandom_range(0, 2));
    c.zero_extend = 1'($urandom_range(0, 1));
    c.first_reg = 4'($urandom_range(0, 15));
    c.second_reg = 4'($urandom_range(0, 15));
    c.displacement = ($urandom_range(0, 1) != 0) ? 16'($urandom) :
                     16'($signed($urandom_range(0, 15)) - 8);
    c.instr_addr = ($urandom_range(0, 1) != 0) ? $urandom :
                   {20'($urandom_range(0, 1048575)), 12'($urandom_range(0, 63))};
    if (push_sp) begin
      c.operation = lsu_pkg::OP_PUSH;
      c.first_reg = 4'(lsu_pkg::SP_INDEX);
    end
    return c;
  endfunction

  task automatic directed_command(logic [3:0] op, logic [1:0] sz, logic zx,
                                  logic [3:0] rn, logic [3:0] rm,
                                  logic [15:0] d, logic [31:0] pc);
    lsu_pkg::lsu_in_t c;
    c.operation = op;
    c.access_size = sz;
    c.zero_extend = zx;
    c.first_reg = rn;
    c.second_reg = rm;
    c.displacement = d;
    c.instr_addr = pc;
    queue_command(c, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < lsu_pkg::REG_COUNT; i++) model_regs[i] = '0;
    for (int i = 0; i < lsu_pkg::MEM_BYTES; i++) begin
      model_mem[i] = '0;
      mem_valid[i] = 1'b0;
    end
    // Pushes of SP store the decremented SP, the first nonzero data.
    for (int i = 0; i < 4; i++) directed_command(lsu_pkg::OP_PUSH, 2'd2, 1'b0, 4'd15, 4'd0,
                                                 16'h0000, 32'h0);
    directed_command(lsu_pkg::OP_POP, 2'd0, 1'b0, 4'd0, 4'd0, 16'h0000, 32'h0);
    directed_command(lsu_pkg::OP_POP, 2'd0, 1'b0, 4'd15, 4'd3, 16'h0000, 32'h0);
    directed_command(lsu_pkg::OP_PUSH, 2'd2, 1'b0, 4'd15, 4'd0, 16'h0000, 32'h0);
    directed_command(4'd4, 2'd2, 1'b0, 4'd15, 4'd0, 16'h0000, 32'hFFFFFFFE);
    directed_command(4'd5, 2'd0, 1'b0, 4'd1, 4'd0, 16'h0000, 32'hFFFFFFFE);
    directed_command(4'd5, 2'd1, 1'b1, 4'd2, 4'd0, 16'h0000, 32'hFFFFFFFE);
    directed_command(4'd0, 2'd2, 1'b0, 4'd0, 4'd15, 16'h0000, 32'h0);
    directed_command(4'd1, 2'd2, 1'b0, 4'd3, 4'd15, 16'h0000, 32'h0);
    for (int op = 0; op < 14; op++) begin
      directed_command(4'(op), 2'(op % 3), 1'(op / 3), 4'(op), 4'(15 - op),
                       (op % 2) ? 16'h8000 : 16'h7FFF, 32'hFFFFFFFF - op);
    end
    for (int i = 0; i < 550; i++) begin
      queue_command(random_command(i < 60 ? ($urandom_range(0, 2) == 0) :
                                   ($urandom_range(0, 15) == 0)),
                    i == 200 || i == 400);
    end
    wait (cmd_queue.size() == 0 && expected_results.size() == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  logic took = 1'b0;
  int   gap = 0;
  bit   steady = 1'b0;

  always @(posedge clk) begin
    took <= start & ~busy & ~rst;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (took) sent_count <= sent_count + 1;
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (cmd_queue.size() != 0 &&
                   !(cmd_queue[0].drain && recv_count != sent_count + took)) begin
        cmd <= cmd_queue[0].cmd;
        cmd_queue.pop_front();
        start <= 1'b1;
        if ($urandom_range(0, 31) == 0) steady <= ~steady;
        gap <= steady ? 0 : $urandom_range(0, 7);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (recv_count >= sent_count + took || expected_results.size() == 0) begin
        $display("%0t: result transfer with nothing outstanding, actual %h", $time, result);
        errors <= errors + 1;
      end else begin
        if (result.eff_addr !== expected_results[0].eff_addr)
          $display("%0t: eff_addr expected %h actual %h", $time,
                   expected_results[0].eff_addr, result.eff_addr);
        if (result.moved_value !== expected_results[0].moved_value)
          $display("%0t: moved_value expected %h actual %h", $time,
                   expected_results[0].moved_value, result.moved_value);
        if (result.dest_index !== expected_results[0].dest_index)
          $display("%0t: dest_index expected %h actual %h", $time,
                   expected_results[0].dest_index, result.dest_index);
        if (result.reg_written !== expected_results[0].reg_written)
          $display("%0t: reg_written expected %h actual %h", $time,
                   expected_results[0].reg_written, result.reg_written);
        if (result !== expected_results[0]) errors <= errors + 1;
        expected_results.pop_front();
        recv_count <= recv_count + 1;
      end
    end
  end
endmodule
